@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/blt_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte-range lock table package
// Shared record type, compare flags, state codes and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [62:0] LAST_OFFSET = '1;

   // Command codes.
   localparam logic [1:0] CMD_APPLY  = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Lock type codes.
   localparam logic [1:0] LT_UNLOCK = 2'd0;
   localparam logic [1:0] LT_READ   = 2'd1;
   localparam logic [1:0] LT_WRITE  = 2'd2;
   localparam logic [1:0] LT_SPARE  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CONFLICT = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_UNUSED   = 2'd3;

   typedef struct packed {
      logic [63:0] owner;
      logic [63:0] inode;
      logic [62:0] rstart;
      logic [62:0] rend;
      logic        kind;
      logic        space;
      logic [1:0]  ltype;
   } lock_rec_type;

   localparam int REC_W = $bits(lock_rec_type);

   typedef struct packed {
      logic same_set;
      logic same_owner;
      logic overlap;
      logic touch;
      logic conflict;
      logic lt_start;
      logic gt_end;
      logic owner_eq;
      logic inode_eq;
   } cmp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_SPLIT,
      S_COPY_RD,
      S_COPY_WR,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_CONFLICT,
      PH_MERGE,
      PH_STAGE,
      PH_QUERY,
      PH_REMOVE
   } phase_type;

endpackage

@@ src/blt_ram.sv @@
// ----------------------------------------------------------------------------
// Lock table RAM
// Single-write, single-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blt_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/blt_cmp.sv @@
// ----------------------------------------------------------------------------
// Lock record comparator
// Relates the working request range to one stored entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blt_cmp import blt_pkg::*; (
   input  lock_rec_type rep,
   input  lock_rec_type ent,
   output cmp_type      flags
);

   logic adj_after;
   logic adj_before;

   // Adjacency never applies across the end-of-file offset.
   assign adj_after  = (rep.rend != LAST_OFFSET) && ((rep.rend + 63'd1) == ent.rstart);
   assign adj_before = (ent.rend != LAST_OFFSET) && ((ent.rend + 63'd1) == rep.rstart);

   always_comb begin
      flags.same_set   = (rep.inode == ent.inode) && (rep.space == ent.space);
      flags.same_owner = (rep.owner == ent.owner) && (rep.kind == ent.kind);
      flags.overlap    = (rep.rstart <= ent.rend) && (ent.rstart <= rep.rend);
      flags.touch      = flags.overlap || adj_after || adj_before;
      flags.lt_start   = ent.rstart < rep.rstart;
      flags.gt_end     = ent.rend > rep.rend;
      flags.owner_eq   = rep.owner == ent.owner;
      flags.inode_eq   = rep.inode == ent.inode;
      // A conflict needs two real locks, at least one of them a write.
      flags.conflict   = (rep.ltype != LT_UNLOCK) && (ent.ltype != LT_UNLOCK) &&
                         flags.same_set && !flags.same_owner && flags.overlap &&
                         ((rep.ltype == LT_WRITE) || (ent.ltype == LT_WRITE));
   end

endmodule

@@ src/byte_range_lock_table_core.sv @@
// ----------------------------------------------------------------------------
// Byte-range lock table core
// Sequencer over the lock table RAM and a staging RAM for record locks.
// ----------------------------------------------------------------------------
// One request is taken at a time. Every pass over the table reads each stored
// entry from the RAM and then evaluates it, because the table sits in a
// one-port-read RAM with a registered read port. An apply runs a conflict
// pass, which ends the apply when it finds a conflict, a merge pass that
// restarts each time the range grows (skipped for an unlock), a split pass into
// the staging RAM and a copy back of the resulting entries. A result waits in
// an output register, so the next request can be taken once the result is
// registered.
`timescale 1ns / 1ps

module byte_range_lock_table_core import blt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_owner,
   input  logic        req_kind,
   input  logic        req_space,
   input  logic [63:0] req_inode,
   input  logic [1:0]  req_lock_type,
   input  logic [62:0] req_range_start,
   input  logic [62:0] req_range_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [63:0] rsp_rec_owner,
   output logic        rsp_rec_kind,
   output logic        rsp_rec_space,
   output logic [63:0] rsp_rec_inode,
   output logic [1:0]  rsp_rec_type,
   output logic [62:0] rsp_rec_start,
   output logic [62:0] rsp_rec_end
);

   state_type    state_ff, state_in;
   phase_type    phase_ff;
   logic [CNT_W-1:0] idx_ff, n_ff, count_ff;
   lock_rec_type rep_ff, best_ff, rsp_rec_ff;
   logic         found_ff;
   logic [1:0]   status_ff;
   logic         rsp_valid_ff, rsp_found_ff;
   logic [1:0]   rsp_status_ff;

   logic         tbl_wr_en, tbl_rd_en, stg_wr_en, stg_rd_en;
   logic [IDX_W-1:0] tbl_wr_addr, tbl_rd_addr, stg_wr_addr, stg_rd_addr;
   lock_rec_type tbl_wr_data, tbl_rd_data, stg_wr_data, stg_rd_data;
   cmp_type      flags;

   lock_rec_type ent, left_rec, right_rec;
   logic         accept, scan_end, copy_end, full, out_free;
   logic         keep, want, hit, better, rm_match, merge_hit;
   logic [1:0]   ltype_norm;

   assign ent      = tbl_rd_data;
   assign accept   = req_valid && !req_stall;
   assign scan_end = idx_ff >= count_ff;
   assign copy_end = idx_ff >= n_ff;
   assign full     = n_ff >= CNT_W'(CAPACITY);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign ltype_norm = (req_lock_type == LT_SPARE) ? LT_WRITE : req_lock_type;

   blt_ram #(.DEPTH(CAPACITY), .AW(IDX_W), .DW(REC_W)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   blt_ram #(.DEPTH(CAPACITY), .AW(IDX_W), .DW(REC_W)) u_stage (
      .clock   (clock),
      .wr_en   (stg_wr_en),
      .wr_addr (stg_wr_addr),
      .wr_data (stg_wr_data),
      .rd_en   (stg_rd_en),
      .rd_addr (stg_rd_addr),
      .rd_data (stg_rd_data)
   );

   blt_cmp u_cmp (
      .rep   (rep_ff),
      .ent   (ent),
      .flags (flags)
   );

   // Per-entry decisions for the current pass.
   always_comb begin
      keep      = !(flags.same_set && flags.same_owner && flags.overlap);
      want      = keep || flags.lt_start || flags.gt_end;
      better    = !found_ff || (ent.rstart < best_ff.rstart);
      rm_match  = flags.owner_eq && ((rep_ff.inode == 64'd0) || flags.inode_eq);
      merge_hit = flags.same_set && flags.same_owner && (ent.ltype == rep_ff.ltype) &&
                  flags.touch && (flags.lt_start || flags.gt_end);
      if (rep_ff.ltype != LT_UNLOCK) begin
         hit = flags.conflict;
      end else begin
         hit = (phase_ff == PH_QUERY) && rep_ff.kind && !rep_ff.space &&
               flags.same_set && flags.same_owner && flags.overlap;
      end
      left_rec       = ent;
      left_rec.rend  = rep_ff.rstart - 63'd1;
      right_rec        = ent;
      right_rec.rstart = rep_ff.rend + 63'd1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_APPLY || req_command == CMD_QUERY ||
                   req_command == CMD_REMOVE) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD: begin
            if (scan_end) begin
               unique case (phase_ff)
                  PH_CONFLICT: state_in = found_ff ? S_DONE : S_RD;
                  PH_MERGE:    state_in = S_RD;
                  PH_STAGE:    state_in = S_COPY_RD;
                  default:     state_in = S_DONE;
               endcase
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            if (phase_ff == PH_STAGE && want && full) begin
               state_in = S_DONE;
            end else if (phase_ff == PH_STAGE && !keep && flags.lt_start && flags.gt_end) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_RD;
            end
         end
         S_SPLIT:   state_in = full ? S_DONE : S_RD;
         S_COPY_RD: state_in = copy_end ? S_DONE : S_COPY_WR;
         S_COPY_WR: state_in = S_COPY_RD;
         S_DONE:    state_in = out_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // RAM controls.
   always_comb begin
      tbl_rd_en   = (state_ff == S_RD) && !scan_end;
      tbl_rd_addr = idx_ff[IDX_W-1:0];
      tbl_wr_en   = ((state_ff == S_EV) && (phase_ff == PH_REMOVE) && !rm_match) ||
                    (state_ff == S_COPY_WR);
      tbl_wr_addr = (state_ff == S_COPY_WR) ? idx_ff[IDX_W-1:0] : n_ff[IDX_W-1:0];
      tbl_wr_data = (state_ff == S_COPY_WR) ? stg_rd_data : ent;

      stg_rd_en   = (state_ff == S_COPY_RD) && !copy_end;
      stg_rd_addr = idx_ff[IDX_W-1:0];
      stg_wr_addr = n_ff[IDX_W-1:0];
      stg_wr_en   = 1'b0;
      stg_wr_data = right_rec;
      priority if ((state_ff == S_RD) && scan_end && (phase_ff == PH_MERGE)) begin
         stg_wr_en   = 1'b1;
         stg_wr_data = rep_ff;
      end else if ((state_ff == S_EV) && (phase_ff == PH_STAGE) && want && !full) begin
         stg_wr_en = 1'b1;
         if (keep) begin
            stg_wr_data = ent;
         end else if (flags.lt_start) begin
            stg_wr_data = left_rec;
         end else begin
            stg_wr_data = right_rec;
         end
      end else if ((state_ff == S_SPLIT) && !full) begin
         stg_wr_en = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_RD) && scan_end && (phase_ff == PH_REMOVE)) begin
            count_ff <= n_ff;
         end
         if ((state_ff == S_COPY_RD) && copy_end) begin
            count_ff <= n_ff;
         end
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rep_ff.owner  <= req_owner;
               rep_ff.inode  <= req_inode;
               rep_ff.rstart <= req_range_start;
               rep_ff.rend   <= req_range_end;
               rep_ff.kind   <= req_kind;
               rep_ff.space  <= req_space;
               rep_ff.ltype  <= ltype_norm;
               idx_ff        <= '0;
               n_ff          <= '0;
               found_ff      <= 1'b0;
               status_ff     <= ST_OK;
               if (req_command == CMD_QUERY) begin
                  phase_ff <= PH_QUERY;
               end else if (req_command == CMD_REMOVE) begin
                  phase_ff <= PH_REMOVE;
               end else begin
                  phase_ff <= PH_CONFLICT;
               end
            end
         end
         S_RD: begin
            if (scan_end) begin
               idx_ff <= '0;
               unique case (phase_ff)
                  PH_CONFLICT: begin
                     if (found_ff) begin
                        status_ff <= ST_CONFLICT;
                        found_ff  <= 1'b0;
                     end else begin
                        phase_ff <= (rep_ff.ltype != LT_UNLOCK) ? PH_MERGE : PH_STAGE;
                     end
                  end
                  PH_MERGE: begin
                     phase_ff <= PH_STAGE;
                     n_ff     <= CNT_W'(1);
                  end
                  PH_REMOVE: found_ff <= n_ff != count_ff;
                  default: ;
               endcase
            end
         end
         S_EV: begin
            unique case (phase_ff)
               PH_CONFLICT, PH_QUERY: begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (hit && better) begin
                     best_ff  <= ent;
                     found_ff <= 1'b1;
                  end
               end
               PH_MERGE: begin
                  if (merge_hit) begin
                     idx_ff <= '0;
                     if (flags.lt_start) rep_ff.rstart <= ent.rstart;
                     if (flags.gt_end) rep_ff.rend <= ent.rend;
                  end else begin
                     idx_ff <= idx_ff + CNT_W'(1);
                  end
               end
               PH_STAGE: begin
                  if (want) begin
                     if (full) begin
                        status_ff <= ST_FULL;
                     end else begin
                        n_ff <= n_ff + CNT_W'(1);
                     end
                  end
                  // A split entry stays put until its right piece is staged.
                  if (keep || !flags.lt_start || !flags.gt_end) begin
                     idx_ff <= idx_ff + CNT_W'(1);
                  end
               end
               PH_REMOVE: begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (!rm_match) n_ff <= n_ff + CNT_W'(1);
               end
               default: ;
            endcase
         end
         S_SPLIT: begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (full) begin
               status_ff <= ST_FULL;
            end else begin
               n_ff <= n_ff + CNT_W'(1);
            end
         end
         S_COPY_WR: idx_ff <= idx_ff + CNT_W'(1);
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_rec_ff    <= (found_ff && (phase_ff == PH_QUERY)) ? best_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_rec_owner = rsp_rec_ff.owner;
   assign rsp_rec_kind  = rsp_rec_ff.kind;
   assign rsp_rec_space = rsp_rec_ff.space;
   assign rsp_rec_inode = rsp_rec_ff.inode;
   assign rsp_rec_type  = rsp_rec_ff.ltype;
   assign rsp_rec_start = rsp_rec_ff.rstart;
   assign rsp_rec_end   = rsp_rec_ff.rend;

endmodule

@@ src/blt_checker.sv @@
// ----------------------------------------------------------------------------
// Lock table port checker
// Watches the ports of the lock table core over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blt_checker import blt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_found,
   input logic [63:0] rsp_rec_owner,
   input logic [62:0] rsp_rec_start,
   input logic [1:0]  rsp_rec_type
);

   // A stalled transfer stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Status never takes the unused code.
   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status != ST_UNUSED)

   // A refused or full apply never reports a record.
   `ASSERT_IMPLY(a_fail_nofound, clock, reset, rsp_valid && rsp_status != ST_OK, !rsp_found)

   // Without a found record, the record fields read as zero.
   `ASSERT_IMPLY(a_zero_rec, clock, reset, rsp_valid && !rsp_found,
      rsp_rec_owner == 64'd0 && rsp_rec_start == 63'd0 && rsp_rec_type == LT_UNLOCK)

endmodule

bind byte_range_lock_table_core blt_checker u_blt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_found     (rsp_found),
   .rsp_rec_owner (rsp_rec_owner),
   .rsp_rec_start (rsp_rec_start),
   .rsp_rec_type  (rsp_rec_type)
);
